/* hdl/lookahead_peak_limiter_top_macros.svh */
// Assertion helpers for the peak limiter. Clock clk_i, reset rst_ni.
`ifndef LOOKAHEAD_PEAK_LIMITER_TOP_MACROS_SVH
`define LOOKAHEAD_PEAK_LIMITER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LPL_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Property that must hold in the cycle after a trigger.
`define LPL_ASSERT_NEXT(lbl, trig, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (expr)) \
    else $error(msg);

`endif

/* hdl/lpl_pkg.sv */
// ----------------------------------------------------------------------------
// lpl_pkg
// Shared constants, operation codes and control structs of the peak limiter.
// ----------------------------------------------------------------------------
package lpl_pkg;

  localparam int LOOKAHEAD_MAX_DEF = 256;
  localparam int SAMPLE_BITS_DEF   = 24;

  // configuration register widths and indexes
  localparam int GAIN_W    = 23;
  localparam int CEIL_W    = 23;
  localparam int REL_W     = 24;
  localparam int LA_W      = 9;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHD = 2'd3;

  localparam logic [GAIN_W-1:0] GAIN_RST = 23'd524288;
  localparam logic [CEIL_W-1:0] CEIL_RST = 23'd8388607;
  localparam logic [REL_W-1:0]  REL_RST  = 24'd16773721;
  localparam logic [LA_W-1:0]   LA_RST   = 9'd240;

  // smoothed gain, Q1.24
  localparam int            UNITY_W = 25;
  localparam logic [24:0]   UNITY   = 25'd16777216;

  // restoring divide, one quotient bit per cycle
  localparam logic [4:0]  DIV_LAST  = 5'd23;

  // datapath operations
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE  = 5'd1;
  localparam logic [OP_W-1:0] OP_MAG_L    = 5'd2;
  localparam logic [OP_W-1:0] OP_MAG_R    = 5'd3;
  localparam logic [OP_W-1:0] OP_PEAK     = 5'd4;
  localparam logic [OP_W-1:0] OP_POP_RD   = 5'd5;
  localparam logic [OP_W-1:0] OP_POP_BACK = 5'd6;
  localparam logic [OP_W-1:0] OP_PUSH     = 5'd7;
  localparam logic [OP_W-1:0] OP_EMIT_RD  = 5'd8;
  localparam logic [OP_W-1:0] OP_EMIT_HD  = 5'd9;
  localparam logic [OP_W-1:0] OP_DIV      = 5'd10;
  localparam logic [OP_W-1:0] OP_REL      = 5'd11;
  localparam logic [OP_W-1:0] OP_REL2     = 5'd12;
  localparam logic [OP_W-1:0] OP_LIM_L1   = 5'd13;
  localparam logic [OP_W-1:0] OP_LIM_L2   = 5'd14;
  localparam logic [OP_W-1:0] OP_LIM_L3   = 5'd15;
  localparam logic [OP_W-1:0] OP_LIM_R2   = 5'd16;
  localparam logic [OP_W-1:0] OP_LIM_R3   = 5'd17;
  localparam logic [OP_W-1:0] OP_FIN      = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic is_flush;
    logic pend_zero;
    logic qcnt_zero;
    logic pop_hit;
    logic emit_due;
    logic over_ceil;
    logic div_done;
    logic des_lt_g;
    logic out_free;
  } status_t;

endpackage

/* hdl/lookahead_peak_limiter_top.sv */
// Stereo lookahead peak limiter. Each request is either a stereo frame
// (tuser 0) or a flush tick (tuser 1). Frames are held in a delay line of up
// to LOOKAHEAD_MAX entries; once lookahead_frames are pending, the oldest one
// is sent out scaled by a smoothed gain derived from the peak of all pending
// frames, and clamped to +/- ceiling. A flush tick sends out the oldest
// pending frame (none if empty); the one that empties the line carries tlast
// and returns gain, engaged flag and queue to their start state. Requests are
// taken one at a time. A frame is scaled and its peak found; every peak not
// above it is dropped from the back of the sliding-max queue (one queue
// memory read port) before the new peak is pushed. One frame may drop up to
// LOOKAHEAD_MAX-1 entries, but on average at most one per frame since each
// frame pushes one. A request that produces an output reads the oldest frame
// and the queue head, runs the bit-serial ceiling/peak divide when the peak
// is above the ceiling, lowers or releases the gain and limits both channels.
// The result is registered in its last step. The finished output waits in a
// register, so the next request is taken while it is still unclaimed; the
// following output stalls until that register is free. Memories need no
// clearing after reset.
// ----------------------------------------------------------------------------
// lookahead_peak_limiter_top
// Top level: stream ports, configuration port, controller and datapath.
// ----------------------------------------------------------------------------
module lookahead_peak_limiter_top #(
  parameter int LOOKAHEAD_MAX = lpl_pkg::LOOKAHEAD_MAX_DEF,
  parameter int SAMPLE_BITS   = lpl_pkg::SAMPLE_BITS_DEF,
  localparam int DW           = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [DW-1:0]                 s_axis_tdata,  // left_sample, right_sample
  input  logic                          s_axis_tuser,  // req_type
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [DW-1:0]                 m_axis_tdata,  // left_out, right_out
  output logic                          m_axis_tlast,  // stream_end
  output logic                          m_axis_tuser,  // engaged flag
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [lpl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lpl_pkg::CFG_W-1:0]     cfg_data_i
);

  lpl_pkg::cmd_t    cmd;
  lpl_pkg::status_t status;
  logic [SAMPLE_BITS-1:0] out_l, out_r;

  lpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lpl_datapath #(
    .LOOKAHEAD_MAX (LOOKAHEAD_MAX),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_left_i     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_right_i    (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .in_flush_i    (s_axis_tuser),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_left_o    (out_l),
    .out_right_o   (out_r),
    .out_last_o    (m_axis_tlast),
    .out_engaged_o (m_axis_tuser)
  );

  assign m_axis_tdata = DW'({out_r, out_l});

endmodule

/* hdl/lpl_datapath.sv */
// ----------------------------------------------------------------------------
// lpl_datapath
// Registers, delay and max-queue memories, shared multiplier and divider.
// ----------------------------------------------------------------------------
`include "lookahead_peak_limiter_top_macros.svh"

module lpl_datapath #(
  parameter int LOOKAHEAD_MAX = lpl_pkg::LOOKAHEAD_MAX_DEF,
  parameter int SAMPLE_BITS   = lpl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lpl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lpl_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic [SAMPLE_BITS-1:0]         in_left_i,
  input  logic [SAMPLE_BITS-1:0]         in_right_i,
  input  logic                           in_flush_i,
  input  lpl_pkg::cmd_t                  cmd_i,
  output lpl_pkg::status_t               status_o,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [SAMPLE_BITS-1:0]         out_left_o,
  output logic [SAMPLE_BITS-1:0]         out_right_o,
  output logic                           out_last_o,
  output logic                           out_engaged_o
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(LOOKAHEAD_MAX);
  localparam int CW  = $clog2(LOOKAHEAD_MAX + 1);
  localparam int MW  = SB + 4;                  // gained magnitude
  localparam int AMW = (MW > 25) ? MW : 25;     // multiplier operand A
  localparam int PW  = AMW + 25;                // product
  localparam int XW  = (MW > 23) ? MW : 23;     // peak vs ceiling compare
  localparam int QW  = AW + MW;                 // queue entry: pos, peak
  localparam int UW  = lpl_pkg::UNITY_W;

  // configuration
  logic [lpl_pkg::GAIN_W-1:0] gain_cfg_q;
  logic [lpl_pkg::CEIL_W-1:0] ceil_q;
  logic [lpl_pkg::REL_W-1:0]  rel_q;
  logic [lpl_pkg::LA_W-1:0]   la_q;

  // payload
  logic [SB-1:0]   in_l_q, in_r_q;
  logic            flush_q;
  logic [PW-1:0]   prod_q;
  logic [MW-1:0]   tmp_q, peak_q, hpk_q, rem_q;
  logic [2*SB-1:0] frd_q;
  logic [QW-1:0]   qrd_q;
  logic [UW-1:0]   des_q;
  logic [SB-1:0]   oll_q, olr_q;
  logic [SB-1:0]   out_l_q, out_r_q;
  logic            out_last_q, out_eng_q;

  // control
  logic [AW-1:0]   qhead_q, wpos_q;
  logic [CW-1:0]   qcnt_q, pend_q;
  logic [UW-1:0]   gain_q;
  logic            eng_q;
  logic [4:0]      dcnt_q;
  logic            out_valid_q;

  logic [2*SB-1:0] frame_mem [LOOKAHEAD_MAX];
  logic [QW-1:0]   queue_mem [LOOKAHEAD_MAX];

  logic [SB-1:0]   abs_il, abs_ir, abs_fl, abs_fr;
  logic [AMW-1:0]  mul_a;
  logic [24:0]     mul_b;
  logic [PW-1:0]   mul_p;
  logic [MW-1:0]   r19, head_pk;
  logic [CW:0]     rp_sum, bk_sum, tl_sum;
  logic [AW-1:0]   rp, back_idx, tail_idx, wpos_nx, head_nx, qra;
  logic [CW-1:0]   eff_l;
  logic [MW:0]     rem2;
  logic            div_ge, out_free;
  logic [UW-1:0]   g_diff;
  logic            drain_fin, stream_clear;

  function automatic logic [SB-1:0] lim_out(input logic [PW-1:0] p,
                                            input logic [lpl_pkg::CEIL_W-1:0] c,
                                            input logic neg);
    logic [PW-1:0] m;
    logic [SB-1:0] s;
    m = (p + PW'(1 << 23)) >> 24;
    if (m > PW'(c)) m = PW'(c);
    s = SB'(m);
    return neg ? (~s + SB'(1)) : s;
  endfunction

  assign abs_il = in_l_q[SB-1] ? (~in_l_q + SB'(1)) : in_l_q;
  assign abs_ir = in_r_q[SB-1] ? (~in_r_q + SB'(1)) : in_r_q;
  assign abs_fl = frd_q[SB-1] ? (~frd_q[SB-1:0] + SB'(1)) : frd_q[SB-1:0];
  assign abs_fr = frd_q[2*SB-1] ? (~frd_q[2*SB-1:SB] + SB'(1)) : frd_q[2*SB-1:SB];

  assign r19    = MW'((prod_q + PW'(1 << 18)) >> 19);
  assign g_diff = des_q - gain_q;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      lpl_pkg::OP_MAG_L: begin
        mul_a = AMW'(abs_il);
        mul_b = 25'(gain_cfg_q);
      end
      lpl_pkg::OP_MAG_R: begin
        mul_a = AMW'(abs_ir);
        mul_b = 25'(gain_cfg_q);
      end
      lpl_pkg::OP_REL: begin
        mul_a = AMW'(g_diff);
        mul_b = lpl_pkg::UNITY - 25'(rel_q);
      end
      lpl_pkg::OP_LIM_L1: begin
        mul_a = AMW'(abs_fl);
        mul_b = 25'(gain_cfg_q);
      end
      lpl_pkg::OP_LIM_L3: begin
        mul_a = AMW'(abs_fr);
        mul_b = 25'(gain_cfg_q);
      end
      lpl_pkg::OP_LIM_L2, lpl_pkg::OP_LIM_R2: begin
        mul_a = AMW'(r19);
        mul_b = gain_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // ring arithmetic
  always_comb begin
    rp_sum   = (CW+1)'(wpos_q) + (CW+1)'(LOOKAHEAD_MAX) - (CW+1)'(pend_q);
    rp       = (rp_sum >= (CW+1)'(LOOKAHEAD_MAX)) ?
               AW'(rp_sum - (CW+1)'(LOOKAHEAD_MAX)) : AW'(rp_sum);
    bk_sum   = (CW+1)'(qhead_q) + (CW+1)'(qcnt_q) - (CW+1)'(1);
    back_idx = (bk_sum >= (CW+1)'(LOOKAHEAD_MAX)) ?
               AW'(bk_sum - (CW+1)'(LOOKAHEAD_MAX)) : AW'(bk_sum);
    tl_sum   = (CW+1)'(qhead_q) + (CW+1)'(qcnt_q);
    tail_idx = (tl_sum >= (CW+1)'(LOOKAHEAD_MAX)) ?
               AW'(tl_sum - (CW+1)'(LOOKAHEAD_MAX)) : AW'(tl_sum);
    wpos_nx  = (wpos_q == AW'(LOOKAHEAD_MAX - 1)) ? '0 : wpos_q + AW'(1);
    head_nx  = (qhead_q == AW'(LOOKAHEAD_MAX - 1)) ? '0 : qhead_q + AW'(1);
    qra      = (cmd_i.op == lpl_pkg::OP_POP_RD) ? back_idx : qhead_q;
  end

  // window length, clipped to 1..LOOKAHEAD_MAX
  always_comb begin
    if (la_q == '0) begin
      eff_l = CW'(1);
    end else if (32'(la_q) > 32'(LOOKAHEAD_MAX)) begin
      eff_l = CW'(LOOKAHEAD_MAX);
    end else begin
      eff_l = CW'(la_q);
    end
  end

  assign head_pk = (qcnt_q != '0) ? qrd_q[MW-1:0] : '0;
  assign rem2    = {rem_q, 1'b0};
  assign div_ge  = rem2 >= (MW+1)'(hpk_q);
  assign out_free = !out_valid_q || out_ready_i;

  assign drain_fin    = (cmd_i.op == lpl_pkg::OP_FIN) && flush_q && (pend_q == CW'(1));
  assign stream_clear = (pend_q == '0) && (qcnt_q == '0) && (gain_q == lpl_pkg::UNITY) && !eng_q;

  always_comb begin
    status_o.is_flush  = flush_q;
    status_o.pend_zero = (pend_q == '0);
    status_o.qcnt_zero = (qcnt_q == '0);
    status_o.pop_hit   = (qrd_q[MW-1:0] <= peak_q);
    status_o.emit_due  = (pend_q >= eff_l);
    status_o.over_ceil = (XW'(head_pk) > XW'(ceil_q));
    status_o.div_done  = (dcnt_q == lpl_pkg::DIV_LAST);
    status_o.des_lt_g  = (des_q < gain_q);
    status_o.out_free  = out_free;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_cfg_q <= lpl_pkg::GAIN_RST;
      ceil_q     <= lpl_pkg::CEIL_RST;
      rel_q      <= lpl_pkg::REL_RST;
      la_q       <= lpl_pkg::LA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lpl_pkg::REG_GAIN:    gain_cfg_q <= cfg_data_i[lpl_pkg::GAIN_W-1:0];
        lpl_pkg::REG_CEILING: ceil_q     <= cfg_data_i[lpl_pkg::CEIL_W-1:0];
        lpl_pkg::REG_RELEASE: rel_q      <= cfg_data_i[lpl_pkg::REL_W-1:0];
        lpl_pkg::REG_LOOKAHD: la_q       <= cfg_data_i[lpl_pkg::LA_W-1:0];
        default: ;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lpl_pkg::OP_PEAK) begin
      frame_mem[wpos_q] <= {in_r_q, in_l_q};
    end
    if (cmd_i.op == lpl_pkg::OP_EMIT_RD) begin
      frd_q <= frame_mem[rp];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lpl_pkg::OP_PUSH) begin
      queue_mem[tail_idx] <= {wpos_q, peak_q};
    end
    if (cmd_i.op == lpl_pkg::OP_POP_RD || cmd_i.op == lpl_pkg::OP_EMIT_RD) begin
      qrd_q <= queue_mem[qra];
    end
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      lpl_pkg::OP_CAPTURE: begin
        in_l_q  <= in_left_i;
        in_r_q  <= in_right_i;
        flush_q <= in_flush_i;
      end
      lpl_pkg::OP_MAG_L: prod_q <= mul_p;
      lpl_pkg::OP_MAG_R: begin
        tmp_q  <= r19;
        prod_q <= mul_p;
      end
      lpl_pkg::OP_PEAK: peak_q <= (r19 > tmp_q) ? r19 : tmp_q;
      lpl_pkg::OP_EMIT_HD: begin
        hpk_q  <= head_pk;
        rem_q  <= MW'(ceil_q);
        des_q  <= status_o.over_ceil ? '0 : lpl_pkg::UNITY;
      end
      lpl_pkg::OP_DIV: begin
        rem_q <= div_ge ? MW'(rem2 - (MW+1)'(hpk_q)) : MW'(rem2);
        des_q <= {des_q[UW-2:0], div_ge};
      end
      lpl_pkg::OP_REL, lpl_pkg::OP_LIM_L1, lpl_pkg::OP_LIM_L2,
      lpl_pkg::OP_LIM_R2: prod_q <= mul_p;
      lpl_pkg::OP_LIM_L3: begin
        oll_q  <= lim_out(prod_q, ceil_q, frd_q[SB-1]);
        prod_q <= mul_p;
      end
      lpl_pkg::OP_LIM_R3: olr_q <= lim_out(prod_q, ceil_q, frd_q[2*SB-1]);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == lpl_pkg::OP_FIN) begin
      out_l_q    <= oll_q;
      out_r_q    <= olr_q;
      out_last_q <= flush_q && (pend_q == CW'(1));
      out_eng_q  <= eng_q;
    end
  end

  // output register valid: a new result may replace one taken in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == lpl_pkg::OP_FIN) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qhead_q     <= '0;
      qcnt_q      <= '0;
      wpos_q      <= '0;
      pend_q      <= '0;
      gain_q      <= lpl_pkg::UNITY;
      eng_q       <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      case (cmd_i.op)
        lpl_pkg::OP_POP_BACK: qcnt_q <= qcnt_q - CW'(1);
        lpl_pkg::OP_PUSH: begin
          qcnt_q <= qcnt_q + CW'(1);
          wpos_q <= wpos_nx;
          pend_q <= pend_q + CW'(1);
        end
        lpl_pkg::OP_EMIT_HD: begin
          dcnt_q <= '0;
          if (qcnt_q != '0 && qrd_q[QW-1:MW] == rp) begin
            qhead_q <= head_nx;
            qcnt_q  <= qcnt_q - CW'(1);
          end
        end
        lpl_pkg::OP_DIV: dcnt_q <= dcnt_q + 5'd1;
        lpl_pkg::OP_REL: begin
          if (des_q < gain_q) gain_q <= des_q;
          if (des_q < lpl_pkg::UNITY) eng_q <= 1'b1;
        end
        lpl_pkg::OP_REL2: gain_q <= gain_q + UW'((prod_q + PW'(lpl_pkg::UNITY - 25'd1)) >> 24);
        lpl_pkg::OP_FIN: begin
          // pending count reaches zero on the drain as well
          pend_q <= pend_q - CW'(1);
          if (flush_q && pend_q == CW'(1)) begin
            // drained: back to the start-of-stream state
            qhead_q <= '0;
            qcnt_q  <= '0;
            wpos_q  <= '0;
            gain_q  <= lpl_pkg::UNITY;
            eng_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_left_o    = out_l_q;
  assign out_right_o   = out_r_q;
  assign out_last_o    = out_last_q;
  assign out_engaged_o = out_eng_q;

  `LPL_ASSERT(a_pend_bound, pend_q <= CW'(LOOKAHEAD_MAX), "pending count above depth")
  `LPL_ASSERT(a_queue_le_pend, qcnt_q <= pend_q, "max queue holds more than pending frames")
  `LPL_ASSERT(a_gain_le_unity, gain_q <= lpl_pkg::UNITY, "smoothed gain above unity")
  `LPL_ASSERT_NEXT(a_drain_clear, drain_fin, stream_clear, "stream state not cleared after drain")

endmodule

/* hdl/lpl_ctrl.sv */
// ----------------------------------------------------------------------------
// lpl_ctrl
// Sequencer: per-request steps of push, queue pops, divide and limiting.
// ----------------------------------------------------------------------------
module lpl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lpl_pkg::status_t  status_i,
  output lpl_pkg::cmd_t     cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DISP    = 5'd1;
  localparam logic [4:0] S_MAG_L   = 5'd2;
  localparam logic [4:0] S_MAG_R   = 5'd3;
  localparam logic [4:0] S_PEAK    = 5'd4;
  localparam logic [4:0] S_POP_RD  = 5'd5;
  localparam logic [4:0] S_POP_CHK = 5'd6;
  localparam logic [4:0] S_PUSH    = 5'd7;
  localparam logic [4:0] S_CHECK   = 5'd8;
  localparam logic [4:0] S_EMIT_RD = 5'd9;
  localparam logic [4:0] S_EMIT_HD = 5'd10;
  localparam logic [4:0] S_DIV     = 5'd11;
  localparam logic [4:0] S_REL     = 5'd12;
  localparam logic [4:0] S_REL2    = 5'd13;
  localparam logic [4:0] S_LIM_L1  = 5'd14;
  localparam logic [4:0] S_LIM_L2  = 5'd15;
  localparam logic [4:0] S_LIM_L3  = 5'd16;
  localparam logic [4:0] S_LIM_R2  = 5'd17;
  localparam logic [4:0] S_LIM_R3  = 5'd18;
  localparam logic [4:0] S_FIN     = 5'd19;

  logic [4:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = lpl_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = lpl_pkg::OP_CAPTURE;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (status_i.is_flush) begin
          state_d = status_i.pend_zero ? S_IDLE : S_EMIT_RD;
        end else begin
          state_d = S_MAG_L;
        end
      end
      S_MAG_L: begin
        cmd_o.op = lpl_pkg::OP_MAG_L;
        state_d  = S_MAG_R;
      end
      S_MAG_R: begin
        cmd_o.op = lpl_pkg::OP_MAG_R;
        state_d  = S_PEAK;
      end
      S_PEAK: begin
        cmd_o.op = lpl_pkg::OP_PEAK;
        state_d  = S_POP_RD;
      end
      S_POP_RD: begin
        if (status_i.qcnt_zero) begin
          state_d = S_PUSH;
        end else begin
          cmd_o.op = lpl_pkg::OP_POP_RD;
          state_d  = S_POP_CHK;
        end
      end
      S_POP_CHK: begin
        if (status_i.pop_hit) begin
          cmd_o.op = lpl_pkg::OP_POP_BACK;
          state_d  = S_POP_RD;
        end else begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd_o.op = lpl_pkg::OP_PUSH;
        state_d  = S_CHECK;
      end
      S_CHECK: state_d = status_i.emit_due ? S_EMIT_RD : S_IDLE;
      S_EMIT_RD: begin
        cmd_o.op = lpl_pkg::OP_EMIT_RD;
        state_d  = S_EMIT_HD;
      end
      S_EMIT_HD: begin
        cmd_o.op = lpl_pkg::OP_EMIT_HD;
        state_d  = status_i.over_ceil ? S_DIV : S_REL;
      end
      S_DIV: begin
        cmd_o.op = lpl_pkg::OP_DIV;
        if (status_i.div_done) state_d = S_REL;
      end
      S_REL: begin
        cmd_o.op = lpl_pkg::OP_REL;
        state_d  = status_i.des_lt_g ? S_LIM_L1 : S_REL2;
      end
      S_REL2: begin
        cmd_o.op = lpl_pkg::OP_REL2;
        state_d  = S_LIM_L1;
      end
      S_LIM_L1: begin
        cmd_o.op = lpl_pkg::OP_LIM_L1;
        state_d  = S_LIM_L2;
      end
      S_LIM_L2: begin
        cmd_o.op = lpl_pkg::OP_LIM_L2;
        state_d  = S_LIM_L3;
      end
      S_LIM_L3: begin
        cmd_o.op = lpl_pkg::OP_LIM_L3;
        state_d  = S_LIM_R2;
      end
      S_LIM_R2: begin
        cmd_o.op = lpl_pkg::OP_LIM_R2;
        state_d  = S_LIM_R3;
      end
      S_LIM_R3: begin
        cmd_o.op = lpl_pkg::OP_LIM_R3;
        state_d  = S_FIN;
      end
      S_FIN: begin
        if (status_i.out_free) begin
          cmd_o.op = lpl_pkg::OP_FIN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo lookahead peak limiter: frames and flush
// ticks are streamed in under random backpressure, a model of the
// delay line, sliding-max queue and gain smoother predicts every output frame.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = lpl_pkg::LOOKAHEAD_MAX_DEF;
  localparam int SETTLE     = 200;      // cycles after the last output
  localparam int HOLD_LEN   = 400;      // long receiver stall
  localparam int CYCLE_CAP  = 1500000;

  typedef struct {
    bit          flush;
    logic [23:0] left;
    logic [23:0] right;
  } frame_req_t;

  typedef struct {
    logic [23:0] left;
    logic [23:0] right;
    bit          last;
    bit          engaged;
  } frame_out_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          s_valid = 1'b0;
  logic          s_ready;
  logic [47:0]   s_data = '0;
  logic          s_user = 1'b0;
  logic          m_valid;
  logic          m_ready = 1'b0;
  logic [47:0]   m_data;
  logic          m_last;
  logic          m_user;
  logic          cfg_we = 1'b0;
  logic [lpl_pkg::CFG_IDX_W-1:0] cfg_idx = lpl_pkg::REG_GAIN;
  logic [lpl_pkg::CFG_W-1:0]     cfg_data = '0;

  lookahead_peak_limiter_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .m_axis_tlast  (m_last),
    .m_axis_tuser  (m_user),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Limiter model: register copies and stream state
  // ---------------------------------------------------------------------------
  longint unsigned gain_q419 = lpl_pkg::GAIN_RST;
  longint unsigned ceil_q123 = lpl_pkg::CEIL_RST;
  longint unsigned rel_q024  = lpl_pkg::REL_RST;
  int unsigned     la_reg    = lpl_pkg::LA_RST;

  logic [23:0]     dly_left  [DEPTH];
  logic [23:0]     dly_right [DEPTH];
  int unsigned     mq_pos    [DEPTH];
  longint unsigned mq_peak   [DEPTH];
  int unsigned     mq_head, mq_cnt, wr_pos, n_pending;
  longint unsigned gain_q124;
  bit              engaged;

  frame_req_t  req_queue[$];    // requests waiting for the driver
  frame_out_t  frames_due[$];   // predicted outputs, oldest first
  int          n_mismatch = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_go = 1'b0;

  function automatic void clear_stream();
    mq_head   = 0;
    mq_cnt    = 0;
    wr_pos    = 0;
    n_pending = 0;
    gain_q124 = 64'd16777216;
    engaged   = 1'b0;
  endfunction

  function automatic longint unsigned sample_mag(logic [23:0] s);
    return s[23] ? longint'(-s) & 64'hFFFFFF : longint'(s);
  endfunction

  function automatic longint unsigned gained(logic [23:0] s);
    return (sample_mag(s) * gain_q419 + (64'd1 << 18)) >> 19;
  endfunction

  function automatic logic [23:0] limit(logic [23:0] s);
    longint unsigned m;
    logic [23:0] r;
    m = (gained(s) * gain_q124 + (64'd1 << 23)) >> 24;
    if (m > ceil_q123) m = ceil_q123;
    r = m[23:0];
    return s[23] ? -r : r;
  endfunction

  // Output the oldest pending frame; its window is every pending frame.
  function automatic frame_out_t release_oldest();
    frame_out_t o;
    int unsigned rp, h;
    longint unsigned pk, target, step;
    rp = (wr_pos + DEPTH - n_pending) % DEPTH;
    h  = mq_head % DEPTH;
    pk = mq_cnt ? mq_peak[h] : 0;
    if (mq_cnt && mq_pos[h] == rp) begin
      mq_head = (h + 1) % DEPTH;
      mq_cnt--;
    end
    target = (pk > ceil_q123) ? (ceil_q123 << 24) / pk : 64'd16777216;
    if (target < 64'd16777216) engaged = 1'b1;
    if (target < gain_q124) gain_q124 = target;
    else begin
      step = ((64'd16777216 - rel_q024) * (target - gain_q124) + 64'd16777215) >> 24;
      gain_q124 += step;
    end
    o.left    = limit(dly_left[rp]);
    o.right   = limit(dly_right[rp]);
    o.last    = 1'b0;
    o.engaged = engaged;
    n_pending--;
    return o;
  endfunction

  function automatic void limiter_step(frame_req_t q);
    frame_out_t o;
    longint unsigned pk, pl, pr;
    int unsigned wp, back, eff;
    if (q.flush) begin
      if (n_pending == 0) return;
      o = release_oldest();
      if (n_pending == 0) begin
        o.last = 1'b1;
        clear_stream();
      end
      frames_due = {frames_due, o};
      return;
    end
    pl = gained(q.left);
    pr = gained(q.right);
    pk = (pl > pr) ? pl : pr;
    wp = wr_pos % DEPTH;
    if (n_pending >= DEPTH) begin
      o = release_oldest();
      frames_due = {frames_due, o};
    end
    dly_left[wp]  = q.left;
    dly_right[wp] = q.right;
    while (mq_cnt > 0) begin
      back = (mq_head + mq_cnt - 1) % DEPTH;
      if (mq_peak[back] <= pk) mq_cnt--;
      else break;
    end
    back = (mq_head + mq_cnt) % DEPTH;
    mq_pos[back]  = wp;
    mq_peak[back] = pk;
    mq_cnt++;
    wr_pos = (wp + 1) % DEPTH;
    n_pending++;
    eff = (la_reg == 0) ? 1 : (la_reg > DEPTH) ? DEPTH : la_reg;
    if (n_pending >= eff) begin
      o = release_oldest();
      frames_due = {frames_due, o};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes requests from req_queue, model runs on each accepted one
  // ---------------------------------------------------------------------------
  frame_req_t cur_req;

  always @(posedge clk) begin
    if (rst_n) begin
      if (s_valid && s_ready) limiter_step(cur_req);
      if (!s_valid || s_ready) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_queue[0];
          req_queue.delete(0);
          s_valid <= 1'b1;
          s_user  <= cur_req.flush;
          s_data  <= {cur_req.right, cur_req.left};
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long receiver stall, counted on its own
  // ---------------------------------------------------------------------------
  int  hold_cnt = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_go && !hold_done && hold_cnt == 0) begin
        hold_cnt  <= HOLD_LEN;
        hold_done <= 1'b1;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random tready, held low during the stall, field compare
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    frame_out_t e;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        if (frames_due.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("ERROR: unexpected output L=%h R=%h last=%b eng=%b",
                     m_data[23:0], m_data[47:24], m_last, m_user);
        end else begin
          e = frames_due[0];
          frames_due.delete(0);
          if (m_data[23:0] !== e.left || m_data[47:24] !== e.right ||
              m_last !== e.last || m_user !== e.engaged) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("ERROR: exp L=%h R=%h last=%b eng=%b got L=%h R=%h last=%b eng=%b",
                       e.left, e.right, e.last, e.engaged,
                       m_data[23:0], m_data[47:24], m_last, m_user);
          end
        end
      end
      // long receiver stall so the output register fills and tready drops
      if (hold_cnt > 0 || (hold_go && !hold_done)) begin
        m_ready <= 1'b0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // run-length guard
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [lpl_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val[lpl_pkg::CFG_W-1:0];
    case (idx)
      lpl_pkg::REG_GAIN:    gain_q419 = val & 32'h7FFFFF;
      lpl_pkg::REG_CEILING: ceil_q123 = val & 32'h7FFFFF;
      lpl_pkg::REG_RELEASE: rel_q024  = val & 32'hFFFFFF;
      lpl_pkg::REG_LOOKAHD: la_reg    = val & 32'h1FF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(int unsigned g, int unsigned c, int unsigned r, int unsigned l);
    write_reg(lpl_pkg::REG_GAIN, g);
    write_reg(lpl_pkg::REG_CEILING, c);
    write_reg(lpl_pkg::REG_RELEASE, r);
    write_reg(lpl_pkg::REG_LOOKAHD, l);
  endtask

  task automatic add_frame(logic [23:0] l, logic [23:0] r);
    frame_req_t q;
    q.flush = 1'b0;
    q.left  = l;
    q.right = r;
    req_queue = {req_queue, q};
  endtask

  // flush payload is ignored by the block, so fill it with noise
  task automatic add_flush();
    frame_req_t q;
    q.flush = 1'b1;
    q.left  = 24'($urandom);
    q.right = 24'($urandom);
    req_queue = {req_queue, q};
  endtask

  // Block may still be busy on a request with no output, hence the settle time.
  task automatic wait_idle();
    do @(posedge clk);
    while (req_queue.size() != 0 || s_valid || frames_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(4))
      0:       return 24'($urandom);
      1:       return 24'($signed($urandom_range(2000)) - 1000);
      2:       return $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
      default: return $urandom_range(1) ? 24'($urandom_range(8388607, 3000000))
                                        : -24'($urandom_range(8388607, 3000000));
    endcase
  endfunction

  function automatic int unsigned pick(int unsigned lo, int unsigned hi);
    case ($urandom_range(5))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  initial begin
    int unsigned n_frames, la;
    clear_stream();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: max gain, lowest ceiling, instant release, window of one
    set_all(8388607, 4194304, 0, 1);
    add_flush();                          // nothing pending: no output
    add_frame(24'h7FFFFF, 24'h800000);
    add_frame(24'h800000, 24'h7FFFFF);
    add_frame(24'h000000, 24'h000000);
    add_frame(24'hFFFFFF, 24'h000001);
    add_frame(24'h000001, 24'hFFFFFF);
    add_frame(24'h400000, 24'hC00000);
    add_flush();                          // nothing pending: no output
    add_flush();
    wait_idle();

    // directed: zero gain, full ceiling, slowest release, window of three
    set_all(0, 8388607, 16777215, 3);
    add_frame(24'h7FFFFF, 24'h800000);
    add_frame(24'h123456, 24'hABCDEF);
    add_frame(24'h000000, 24'h7FFFFF);
    add_frame(24'h800000, 24'h000000);
    repeat (4) add_flush();
    wait_idle();

    // gain changed with frames pending, then window shrunk with frames pending
    set_all(524288, 6000000, lpl_pkg::REL_RST, 8);
    repeat (6) add_frame(rand_sample(), rand_sample());
    wait_idle();
    write_reg(lpl_pkg::REG_GAIN, 2000000);
    repeat (4) add_frame(rand_sample(), rand_sample());
    wait_idle();
    write_reg(lpl_pkg::REG_LOOKAHD, 2);
    repeat (3) add_frame(rand_sample(), rand_sample());
    repeat (9) add_flush();
    wait_idle();

    // random phases: receiver idles more, then sender idles more, then no idling
    for (int p = 0; p < 15; p++) begin
      send_idle_pct = (p < 5) ? 7 : (p < 10) ? 68 : 0;
      recv_idle_pct = (p < 5) ? 68 : (p < 10) ? 7 : 0;
      la = ($urandom_range(3) == 0) ? pick(1, 40) : $urandom_range(12, 1);
      if (p == 10) la = 1;                // hold-off stretch: outputs pile up
      set_all(pick(0, 8388607), pick(4194304, 8388607), pick(0, 16777215), la);
      if (p == 10) hold_go = 1'b1;
      n_frames = $urandom_range(20, 8);
      for (int i = 0; i < n_frames; i++) begin
        if ($urandom_range(19) == 0) add_flush();
        add_frame(rand_sample(), rand_sample());
      end
      if ($urandom_range(4) != 0)
        repeat ($urandom_range(la + 2, la)) add_flush();
      wait_idle();
    end

    // deepest window
    set_all(pick(262144, 1048576), pick(4194304, 8388607), lpl_pkg::REL_RST, 256);
    for (int i = 0; i < 262; i++) add_frame(rand_sample(), rand_sample());
    repeat (4) add_flush();
    wait_idle();

    if (n_mismatch == 0 && frames_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/lpl_pkg.sv
hdl/lpl_datapath.sv
hdl/lpl_ctrl.sv
hdl/lookahead_peak_limiter_top.sv
tb/tb.sv
